FILE: src/rrg_pkg.sv
// Shared types and constants of the random range generator.
package rrg_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned QUO_W     = 31;              // dividend and quotient width
    localparam int unsigned DVSR_W    = 33;              // span reaches 2^32
    localparam int unsigned DIV_STEPS = QUO_W;           // one quotient bit per cycle
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam logic [QUO_W-1:0] RAND_CEILING = 31'h7FFF_FFFF;

    localparam int unsigned SHIFT_A = 15;
    localparam int unsigned SHIFT_B = 4;
    localparam int unsigned SHIFT_C = 21;

    localparam logic [DATA_W-1:0] SEED_0 = 32'd1234567890;
    localparam logic [DATA_W-1:0] SEED_1 = 32'd2718281828;
    localparam logic [DATA_W-1:0] SEED_2 = 32'd2953575118;
    localparam logic [DATA_W-1:0] SEED_3 = 32'd3141592653;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV1,
        S_LOAD2,
        S_DIV2,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic take_in;   // latch request, step generator unless bypassed, load first division
        logic div_step;  // one restoring division step
        logic div_load2; // load second division from first quotient
        logic out_load;  // move result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic bypass;    // request at the input has equal or reversed bounds
        logic div_last;  // current division step is the final one
        logic out_free;  // output register can take a result this cycle
    } t_stat;

endpackage

FILE: src/random_range_generator.sv
// Top level of the random range generator.
//
// Usage:
//   Slave channel (i_s_axis_*): one request per transfer, tdata carries
//   low_bound in [31:0] and high_bound in [63:32], both signed.
//   Master channel (o_m_axis_*): one result per request, tdata carries
//   value in [31:0] and raw_word in [63:32]; tuser[0] is range_error.
// Sequencing:
//   A request with distinct, ordered bounds passes from its transfer to the
//   result in the output register through two 31-step restoring divisions in
//   the shared bit-serial divider, a reload state between them and a final
//   load of the output. Equal or reversed bounds skip the divider.
//   The divider handles one request at a time, so the next request transfer
//   can occur the cycle after the result is registered.
// Reset: i_rst_n low at a clock edge loads the fixed generator seeds, clears
//   the sequencer and drops o_m_axis_tvalid.
// Stall: a result waits in the output register while i_m_axis_tready is low;
//   a finished computation holds until the register frees, so no result is
//   lost, and o_s_axis_tready stays low until it has moved on.
module random_range_generator import rrg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] low_bound, [63:32] high_bound
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [31:0] value, [63:32] raw_word
    output logic [0:0]  o_m_axis_tuser    // [0] range_error
);

    t_cmd              cmd;
    t_stat             stat;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] raw_word;
    logic              range_error;

    // Sequencer: intake, division phases, result hand-off
    rrg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Generator, divider and output register
    rrg_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_low_bound   (i_s_axis_tdata[31:0]),
        .i_high_bound  (i_s_axis_tdata[63:32]),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_value       (value),
        .o_raw_word    (raw_word),
        .o_range_error (range_error)
    );

    assign o_m_axis_tdata = {raw_word, value};
    assign o_m_axis_tuser = range_error;

`ifndef SYNTHESIS
    // A reversed-bound result never carries a generator word
    a_err_no_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata[63:32] == 32'd0))
        else $error("range_error result with nonzero raw_word");

    // One request in flight: intake closes right after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request accepted while another is in progress");

    // Divider steps and reloads never overlap an intake
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.take_in, cmd.div_step, cmd.div_load2, cmd.out_load}))
        else $error("conflicting datapath commands");
`endif

endmodule

FILE: src/rrg_ctrl.sv
// Sequencer for request intake, the two divisions and result hand-off.
module rrg_ctrl import rrg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    n_state = i_stat.bypass ? S_DONE : S_DIV1;
                end
            end
            S_DIV1: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_LOAD2;
                end
            end
            S_LOAD2: begin
                o_cmd.div_load2 = 1'b1;
                n_state = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: src/rrg_datapath.sv
// Generator state, shared bit-serial divider and output register.
module rrg_datapath import rrg_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [DATA_W-1:0]   i_low_bound,
    input  logic [DATA_W-1:0]   i_high_bound,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [DATA_W-1:0]   o_value,
    output logic [DATA_W-1:0]   o_raw_word,
    output logic                o_range_error
);

    logic [DATA_W-1:0] r_gen [4];
    logic [DATA_W-1:0] gen_t0, gen_t1, gen_w;

    logic [DATA_W-1:0] r_low;
    logic [DATA_W-1:0] r_raw;
    logic              r_bypass;
    logic              r_err;

    logic [DVSR_W-1:0] r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [DVSR_W-1:0] r_dvsr;
    logic [CNT_W-1:0]  r_cnt;

    logic              in_equal;
    logic              in_reversed;
    logic [DVSR_W-1:0] span;
    logic [DVSR_W:0]   div_shift;
    logic [DVSR_W:0]   div_diff;
    logic              div_bit;
    logic [QUO_W-1:0]  dvsr2;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    logic [DATA_W-1:0] r_out_raw;
    logic              r_out_err;

    // Bound checks on the incoming request
    assign in_equal    = (i_high_bound == i_low_bound);
    assign in_reversed = ($signed(i_high_bound) < $signed(i_low_bound));
    assign span = {i_high_bound[DATA_W-1], i_high_bound}
                - {i_low_bound[DATA_W-1], i_low_bound} + DVSR_W'(1);

    // One xorshift128 step
    assign gen_t0 = r_gen[0] ^ (r_gen[0] << SHIFT_A);
    assign gen_t1 = gen_t0 ^ (gen_t0 >> SHIFT_B);
    assign gen_w  = r_gen[3] ^ (r_gen[3] >> SHIFT_C) ^ gen_t1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen[0] <= SEED_0;
            r_gen[1] <= SEED_1;
            r_gen[2] <= SEED_2;
            r_gen[3] <= SEED_3;
        end else if (i_cmd.take_in && !in_equal && !in_reversed) begin
            r_gen[0] <= r_gen[1];
            r_gen[1] <= r_gen[2];
            r_gen[2] <= r_gen[3];
            r_gen[3] <= gen_w;
        end
    end

    // Restoring division, one quotient bit per step
    assign div_shift = {r_rem, r_quo[QUO_W-1]};
    assign div_diff  = div_shift - {1'b0, r_dvsr};
    assign div_bit   = !div_diff[DVSR_W];
    assign dvsr2     = r_quo + QUO_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_low    <= i_low_bound;
            r_bypass <= in_equal || in_reversed;
            r_err    <= in_reversed;
            r_raw    <= (in_equal || in_reversed) ? '0 : gen_w;
            r_rem    <= '0;
            r_quo    <= RAND_CEILING;
            r_dvsr   <= span;
            r_cnt    <= '0;
        end else if (i_cmd.div_load2) begin
            r_rem    <= '0;
            r_quo    <= r_raw[DATA_W-1:1];
            r_dvsr   <= {{(DVSR_W-QUO_W){1'b0}}, dvsr2};
            r_cnt    <= '0;
        end else if (i_cmd.div_step) begin
            r_rem    <= div_bit ? div_diff[DVSR_W-1:0] : div_shift[DVSR_W-1:0];
            r_quo    <= {r_quo[QUO_W-2:0], div_bit};
            r_cnt    <= r_cnt + CNT_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value <= r_bypass ? r_low : ({1'b0, r_quo} + r_low);
            r_out_raw   <= r_raw;
            r_out_err   <= r_err;
        end
    end

    assign o_stat.bypass   = in_equal || in_reversed;
    assign o_stat.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_value       = r_out_value;
    assign o_raw_word    = r_out_raw;
    assign o_range_error = r_out_err;

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the random range generator: directed, stress and random requests.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rrg_pkg::*;

    localparam int RESET_CYCLES = 5;
    localparam int STALL_LIMIT  = 5000;   // cycles with work pending and no transfer
    localparam int DRAIN_CYCLES = 70;     // a little over the divider path
    localparam int DRAIN_LIMIT  = 20000;

    // Kinds of request that the random part draws from
    localparam int KIND_EQUAL    = 0;
    localparam int KIND_REVERSED = 1;
    localparam int KIND_NARROW   = 2;
    localparam int KIND_POW2     = 3;
    localparam int KIND_ANY      = 4;

    // One expected result, fields in the order of the output channel
    typedef struct packed {
        logic [31:0] value;
        logic [31:0] raw_word;
        logic        range_error;
    } t_draw;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [63:0] s_data  = '0;
    logic        m_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [63:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;

    // Predictor copy of the xorshift128 state
    logic [31:0] gen_words [4];
    t_draw       pending_draws [$];
    int          errors      = 0;
    bit          idling      = 1'b0;   // random gaps on both sides when set
    int          hold_cycles = 0;      // receiver hold-off request, counted down by the receiver
    int          quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    random_range_generator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),          // [31:0] low_bound, [63:32] high_bound
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [31:0] value, [63:32] raw_word
        .o_m_axis_tuser  (o_m_axis_tuser)   // [0] range_error
    );

    // Advance the generator one step and return the new output word.
    function automatic logic [31:0] step_generator();
        logic [31:0] t;
        logic [31:0] w;
        t = gen_words[0];
        w = gen_words[3];
        gen_words[0] = gen_words[1];
        gen_words[1] = gen_words[2];
        gen_words[2] = w;
        t = t ^ (t << SHIFT_A);
        t = t ^ (t >> SHIFT_B);
        w = w ^ (w >> SHIFT_C);
        w = w ^ t;
        gen_words[3] = w;
        return w;
    endfunction

    // Work out the result of one request; steps the generator only for an ordered,
    // non-degenerate range.
    function automatic t_draw predict_draw(int lo, int hi);
        t_draw  d;
        longint span;
        longint divisor;
        longint q;
        d.value       = lo;
        d.raw_word    = '0;
        d.range_error = 1'b0;
        if (hi < lo) begin
            d.range_error = 1'b1;
        end else if (hi > lo) begin
            d.raw_word = step_generator();
            // span is exact in 64 bits: 2 .. 2^32
            span    = longint'(hi) - longint'(lo) + 1;
            divisor = 64'h7FFF_FFFF / span + 1;
            q       = longint'(d.raw_word >> 1) / divisor;
            d.value = 32'(q + longint'(lo));
        end
        return d;
    endfunction

    // No gap unless idling; then mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idling) return 0;
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Offer one request, hold it until the transfer, then record what must come back.
    task automatic send_request(int lo, int hi);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {hi, lo};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_draws.push_back(predict_draw(lo, hi));
    endtask

    // Drop valid and wait until every expected result has arrived.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (pending_draws.size() != 0);
    endtask

    // Pick a bound pair of the given kind; distances are placed anywhere that fits.
    task automatic draw_bounds(input int kind, output int lo, output int hi);
        longint diff;
        longint room;
        longint lo_l;
        int     w;
        int     a;
        int     b;
        case (kind)
            KIND_EQUAL: begin
                lo = $urandom;
                hi = lo;
            end
            KIND_REVERSED: begin
                a = $urandom;
                b = $urandom;
                if (a == b) b = a ^ 1;
                lo = (a > b) ? a : b;
                hi = (a > b) ? b : a;
            end
            KIND_NARROW, KIND_POW2: begin
                if (kind == KIND_NARROW) begin
                    diff = $urandom_range(1, 1000);
                end else begin
                    // land on, just under or just over a power of two
                    w    = $urandom_range(1, 32);
                    diff = (64'd1 << w) - 2 + $urandom_range(0, 2);
                end
                if (diff < 1) diff = 1;
                if (diff > 64'hFFFF_FFFF) diff = 64'hFFFF_FFFF;
                room = 64'hFFFF_FFFF - diff;
                lo_l = ({$urandom, $urandom} % (room + 1)) - 64'sd2147483648;
                lo   = 32'(lo_l);
                hi   = 32'(lo_l + diff);
            end
            default: begin
                lo = $urandom;
                hi = $urandom;
            end
        endcase
    endtask

    // Compare one result transfer against the oldest expectation.
    task automatic check_result();
        t_draw want;
        t_draw got;
        got = {o_m_axis_tdata[31:0], o_m_axis_tdata[63:32], o_m_axis_tuser[0]};
        if (pending_draws.size() == 0) begin
            $display("%0t: unexpected result, actual value %h raw %h error %b",
                     $time, got.value, got.raw_word, got.range_error);
            errors++;
            return;
        end
        want = pending_draws.pop_front();
        if (got.value !== want.value) begin
            $display("%0t: value mismatch, expected %h, actual %h",
                     $time, want.value, got.value);
            errors++;
        end
        if (got.raw_word !== want.raw_word) begin
            $display("%0t: raw_word mismatch, expected %h, actual %h",
                     $time, want.raw_word, got.raw_word);
            errors++;
        end
        if (got.range_error !== want.range_error) begin
            $display("%0t: range_error mismatch, expected %b, actual %b",
                     $time, want.range_error, got.range_error);
            errors++;
        end
    endtask

    // Receiver: check each transfer, then choose tready for the next cycle.
    // A requested hold-off keeps tready low for that many cycles regardless of idling.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && m_ready) check_result();
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else if (!idling) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
                if (stall_left > 0) begin
                    m_ready <= 1'b0;
                    stall_left--;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: end the run when work is pending and nothing moves for too long.
    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready) ||
            (!s_valid && pending_draws.size() == 0)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    // Equal bounds: value is the bound itself, generator untouched.
    task automatic test_equal_bounds();
        send_request(0, 0);
        send_request(32'sh8000_0000, 32'sh8000_0000);
        send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_request(-1, -1);
    endtask

    // Reversed bounds: error flag, value is low_bound, generator untouched.
    task automatic test_reversed_bounds();
        send_request(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_request(1, 0);
        send_request(0, -1);
        send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFE);
        send_request(-5, 32'sh8000_0000);
    endtask

    // Span extremes: the full 32-bit range, span two, and spans around 2^31 where
    // the divisor moves between one and two.
    task automatic test_edge_spans();
        send_request(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_request(0, 1);
        send_request(32'sh7FFF_FFFE, 32'sh7FFF_FFFF);
        send_request(32'sh8000_0000, 32'sh8000_0001);
        send_request(0, 32'sh7FFF_FFFE);
        send_request(0, 32'sh7FFF_FFFF);
        send_request(-1, 32'sh7FFF_FFFF);
        send_request(32'sh8000_0000, -1);
        send_request(-100, 100);
        send_request(32'sh8000_0000, 32'sh7FFF_FFFE);
        send_request(32'sh8000_0001, 32'sh7FFF_FFFF);
        send_request(-3, -1);
    endtask

    // Hold the receiver off while requests keep coming, so the output register and
    // the divider fill and the input stalls; then pause until all results are back.
    task automatic test_backpressure();
        int lo;
        int hi;
        idling      = 1'b0;
        hold_cycles = 300;
        repeat (8) begin
            draw_bounds(KIND_NARROW, lo, hi);
            send_request(lo, hi);
        end
        wait_for_drain();
    endtask

    // Random mix of request kinds, with or without gaps on both sides.
    task automatic test_random_mix(int count, bit with_gaps);
        int lo;
        int hi;
        int r;
        int kind;
        idling = with_gaps;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 10)      kind = KIND_EQUAL;
            else if (r < 20) kind = KIND_REVERSED;
            else if (r < 45) kind = KIND_NARROW;
            else if (r < 60) kind = KIND_POW2;
            else             kind = KIND_ANY;
            draw_bounds(kind, lo, hi);
            send_request(lo, hi);
        end
    endtask

    initial begin : stimulus
        int waited;
        gen_words = '{SEED_0, SEED_1, SEED_2, SEED_3};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idling = 1'b1;
        test_equal_bounds();
        test_reversed_bounds();
        test_edge_spans();
        wait_for_drain();
        test_backpressure();
        test_random_mix(200, 1'b0);
        test_random_mix(1000, 1'b1);

        // Drop valid, wait for the last results, then let the divider path run out.
        s_valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending_draws.size() != 0 && waited < DRAIN_LIMIT);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_draws.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_draws.size());
            errors++;
        end
        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

FILE: random_range_generator.f
src/rrg_pkg.sv
src/rrg_ctrl.sv
src/rrg_datapath.sv
src/random_range_generator.sv
bench/testbench.sv
